// ----- rtl/mnd_pkg.sv -----
package mnd_pkg;

	// default table depth and rounding scale
	localparam int unsigned MaxNodesDef   = 1024;
	localparam int unsigned RoundScaleDef = 1000;

	localparam int unsigned KeyW   = 26;
	localparam int unsigned CoordW = 32;
	localparam int unsigned IdxW   = 10;
	localparam logic [KeyW-1:0] KeyMax = 26'h1FF_FFFF;

	// classified item passed from front to back
	typedef struct packed {
		logic            new_mesh;
		logic [KeyW-1:0] kx;
		logic [KeyW-1:0] ky;
	} key_item_t;

	// result item
	typedef struct packed {
		logic [IdxW-1:0] node_index;
		logic            is_new;
		logic [KeyW-1:0] key_x;
		logic [KeyW-1:0] key_y;
		logic            table_full;
	} result_t;

endpackage

// ----- rtl/mesh_node_dedup_unit.sv -----
// Items pass the rounding stages and the queue, then a scan of the key
// table, one entry at a time through its single read port, up to the
// match index or the table fill on a miss. The scan takes a new item
// only after its last result has moved into the output register.
// Reset: arst_n clears the node count, queue and all valid flags at once.
module mesh_node_dedup_unit #(
	parameter int unsigned MAX_NODES   = mnd_pkg::MaxNodesDef,
	parameter int unsigned ROUND_SCALE = mnd_pkg::RoundScaleDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // x_coord[31:0], y_coord[63:32]
	input  logic        s_axis_tuser,  // new_mesh
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // node_index, rounded_x, rounded_y, zero
	output logic [1:0]  m_axis_tuser   // is_new, table_full
);
	logic f_v, f_r, q_v, q_r;
	mnd_pkg::key_item_t f_item, q_item;
	mnd_pkg::result_t res;

	mnd_round #(.ROUND_SCALE(ROUND_SCALE)) u_round (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.new_mesh(s_axis_tuser),
		.x_coord(s_axis_tdata[31:0]), .y_coord(s_axis_tdata[63:32]),
		.out_valid(f_v), .out_ready(f_r), .out_item(f_item)
	);

	mnd_fifo u_fifo (
		.clk, .arst_n,
		.in_valid(f_v), .in_ready(f_r), .in_item(f_item),
		.out_valid(q_v), .out_ready(q_r), .out_item(q_item)
	);

	mnd_lookup #(.MAX_NODES(MAX_NODES)) u_lookup (
		.clk, .arst_n,
		.in_valid(q_v), .in_ready(q_r), .in_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_item(res)
	);

	assign m_axis_tdata = {2'b00, res.key_y, res.key_x, res.node_index};
	assign m_axis_tuser = {res.table_full, res.is_new};
endmodule

// ----- rtl/mnd_round.sv -----
// Front part: rounds both coordinates to keys over two stages
module mnd_round #(
	parameter int unsigned ROUND_SCALE = mnd_pkg::RoundScaleDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  new_mesh,
	input  logic [31:0]           x_coord,
	input  logic [31:0]           y_coord,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mnd_pkg::key_item_t    out_item
);
	localparam int unsigned ScW  = $clog2(ROUND_SCALE + 1);
	// product wide enough that the rounded quotient always covers a full key
	localparam int unsigned ProdW = (32 + ScW + 1 > mnd_pkg::KeyW + 16) ?
		(32 + ScW + 1) : (mnd_pkg::KeyW + 16);
	localparam logic [ScW-1:0] Scale = ScW'(ROUND_SCALE);

	logic        v_s1;
	logic        nm_s1, nx_s1, ny_s1;
	logic [31:0] mx_s1, my_s1;
	logic        v_s2;
	logic        nm_s2, nx_s2, ny_s2;
	logic [ProdW-1:0] px_s2, py_s2;
	logic        adv_s2, adv_s1;

	assign adv_s2   = !v_s2 || out_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// stage 1: magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			nm_s1 <= new_mesh;
			nx_s1 <= x_coord[31];
			ny_s1 <= y_coord[31];
			mx_s1 <= x_coord[31] ? (~x_coord + 32'd1) : x_coord;
			my_s1 <= y_coord[31] ? (~y_coord + 32'd1) : y_coord;
		end
	end

	// stage 2: scale multiply (magnitude 2^31 reads as unsigned)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			nm_s2 <= nm_s1;
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			px_s2 <= ProdW'(mx_s1) * ProdW'(Scale);
			py_s2 <= ProdW'(my_s1) * ProdW'(Scale);
		end
	end

	// round, saturate and sign the keys
	function automatic logic [mnd_pkg::KeyW-1:0] to_key(
		input logic [ProdW-1:0] p,
		input logic             neg
	);
		logic [ProdW:0]              sum;
		logic [ProdW-16:0]           q;
		logic [mnd_pkg::KeyW-1:0]    m;
		sum = {1'b0, p} + (ProdW+1)'(32768);
		q   = sum[ProdW:16];
		if (q > (ProdW-15)'(mnd_pkg::KeyMax)) m = mnd_pkg::KeyMax;
		else m = q[mnd_pkg::KeyW-1:0];
		return neg ? (~m + 1'b1) : m;
	endfunction

	assign out_valid         = v_s2;
	assign out_item.new_mesh = nm_s2;
	assign out_item.kx       = to_key(px_s2, nx_s2);
	assign out_item.ky       = to_key(py_s2, ny_s2);
endmodule

// ----- rtl/mnd_fifo.sv -----
// Short queue between front and back
module mnd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mnd_pkg::key_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output mnd_pkg::key_item_t out_item
);
	mnd_pkg::key_item_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != 3'd4);
	assign out_valid = (cnt_q != 3'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule

// ----- rtl/mnd_lookup.sv -----
// Back part: scans the key table key by key, appends on a miss
module mnd_lookup #(
	parameter int unsigned MAX_NODES = mnd_pkg::MaxNodesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mnd_pkg::key_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output mnd_pkg::result_t   out_item
);
	localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	// count wide enough to hold the table fill and a full result index
	localparam int unsigned CW = ($clog2(MAX_NODES + 1) > mnd_pkg::IdxW) ?
		$clog2(MAX_NODES + 1) : mnd_pkg::IdxW;
	localparam logic [CW-1:0] Depth = CW'(MAX_NODES);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic [2*mnd_pkg::KeyW-1:0] key_tab [MAX_NODES];
	logic [2*mnd_pkg::KeyW-1:0] rd_data_q;
	logic [2*mnd_pkg::KeyW-1:0] key_q;
	logic [CW-1:0] count_q, ptr_q;
	logic [CW-1:0] eff_cnt;
	logic          nm_q;
	logic          tab_we;
	mnd_pkg::result_t work_q;
	mnd_pkg::result_t res_q;
	logic          res_v_q;
	logic          res_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = res_v_q;
	assign out_item  = res_q;
	assign eff_cnt   = nm_q ? '0 : count_q;
	assign tab_we    = (state_q == ST_CMP) && (ptr_q >= eff_cnt) && (eff_cnt != Depth);
	// finished scan moves to the output register once that is free
	assign res_load  = (state_q == ST_DONE) && (!res_v_q || out_ready);

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (tab_we) key_tab[eff_cnt[AW-1:0]] <= key_q;
		rd_data_q <= key_tab[ptr_q[AW-1:0]];
	end

	// scan controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (res_load) res_v_q <= 1'b1;
			else if (out_ready) res_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_READ;
				ST_READ: state_q <= ST_CMP;
				ST_CMP: begin
					if (ptr_q >= eff_cnt) begin
						if (eff_cnt != Depth) count_q <= eff_cnt + 1'b1;
						else count_q <= eff_cnt;
						state_q <= ST_DONE;
					end else if (rd_data_q == key_q) begin
						count_q <= eff_cnt;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_DONE: if (res_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (res_load) res_q <= work_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				key_q <= {in_item.kx, in_item.ky};
				nm_q  <= in_item.new_mesh;
				ptr_q <= '0;
				work_q.key_x <= in_item.kx;
				work_q.key_y <= in_item.ky;
			end
			ST_READ: ;
			ST_CMP: begin
				if (ptr_q >= eff_cnt) begin
					work_q.is_new     <= (eff_cnt != Depth);
					work_q.table_full <= (eff_cnt == Depth);
					work_q.node_index <= (eff_cnt != Depth) ?
						eff_cnt[mnd_pkg::IdxW-1:0] : '0;
					nm_q <= 1'b0;
				end else if (rd_data_q == key_q) begin
					work_q.is_new     <= 1'b0;
					work_q.table_full <= 1'b0;
					work_q.node_index <= ptr_q[mnd_pkg::IdxW-1:0];
					nm_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end
endmodule

// ----- rtl/mnd_checker.sv -----
// Port-level checks of the dedup unit
module mnd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	// a result is never both new and full
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("new and full together");

	// a full result carries index zero
	a_full_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[9:0] == 10'd0))
		else $error("full result with index");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped while stalled");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[63:62] == 2'b00))
		else $error("padding set");
endmodule

bind mesh_node_dedup_unit mnd_checker u_mnd_checker (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
